// ===== rtl/bres_pkg.sv =====
// Shared types and constants for the byte record exchange sorter.
`timescale 1ns / 1ps
`default_nettype none

package bres_pkg;

	// Fixed field widths.
	localparam int unsigned SYM_W     = 8;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Character that closes a set.
	localparam logic [SYM_W-1:0] NEWLINE_CODE = 8'd10;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_FONT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd1;
	localparam logic [CFG_W-1:0]     FONT_RESET = 16'd2;
	localparam logic [CFG_W-1:0]     SIZE_RESET = 16'd10;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT_INIT,
		ST_LO_CAP,
		ST_CMP,
		ST_LO_WR,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store_sym;
		logic clr_cnt;
		logic sort_init;
		logic lo_cap;
		logic cmp_step;
		logic lo_wr;
		logic emit_init;
		logic emit_step;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_nl;
		logic cnt_zero;
		logic cnt_last;
		logic n_one;
		logic hi_last;
		logic lo_last;
		logic k_last;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/bres_ctrl.sv =====
// Controller state machine for the byte record exchange sorter.
`timescale 1ns / 1ps
`default_nettype none

module bres_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire bres_pkg::status_t status,
	output bres_pkg::cmd_t        cmd,
	output logic                  busy
);

	bres_pkg::state_t state_q;
	bres_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bres_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			bres_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (status.is_nl) begin
						if (!status.cnt_zero) begin
							state_d = bres_pkg::ST_SORT_INIT;
						end
					end else begin
						cmd.store_sym = 1'b1;
						if (status.cnt_last) begin
							state_d = bres_pkg::ST_SORT_INIT;
						end
					end
				end
			end
			bres_pkg::ST_SORT_INIT: begin
				cmd.sort_init = 1'b1;
				if (status.n_one) begin
					state_d = bres_pkg::ST_EMIT_RD;
				end else begin
					state_d = bres_pkg::ST_LO_CAP;
				end
			end
			bres_pkg::ST_LO_CAP: begin
				cmd.lo_cap = 1'b1;
				state_d    = bres_pkg::ST_CMP;
			end
			bres_pkg::ST_CMP: begin
				cmd.cmp_step = 1'b1;
				if (status.hi_last) begin
					state_d = bres_pkg::ST_LO_WR;
				end
			end
			bres_pkg::ST_LO_WR: begin
				cmd.lo_wr = 1'b1;
				if (status.lo_last) begin
					state_d = bres_pkg::ST_EMIT_RD;
				end else begin
					state_d = bres_pkg::ST_LO_CAP;
				end
			end
			bres_pkg::ST_EMIT_RD: begin
				cmd.emit_init = 1'b1;
				state_d       = bres_pkg::ST_EMIT;
			end
			bres_pkg::ST_EMIT: begin
				cmd.emit_step = 1'b1;
				if (status.k_last) begin
					cmd.clr_cnt = 1'b1;
					state_d     = bres_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bres_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/bres_dp.sv =====
// Datapath for the byte record exchange sorter: entry store, counters, compare and configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module bres_dp #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bres_pkg::cmd_t                    cmd,
	output bres_pkg::status_t                      status,
	input  wire logic [bres_pkg::SYM_W-1:0]        symbol,
	input  wire logic                              cfg_we,
	input  wire logic [bres_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bres_pkg::CFG_W-1:0]        cfg_data,
	output logic [bres_pkg::SYM_W-1:0]             sorted_symbol,
	output logic [bres_pkg::CFG_W-1:0]             font,
	output logic [bres_pkg::CFG_W-1:0]             size
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [bres_pkg::SYM_W-1:0] mem [DEPTH];
	logic [bres_pkg::SYM_W-1:0] rd_q;
	logic [bres_pkg::SYM_W-1:0] cur_q;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              lo_q;
	logic [CW-1:0]              hi_q;
	logic [CW-1:0]              k_q;
	logic [bres_pkg::CFG_W-1:0] font_q;
	logic [bres_pkg::CFG_W-1:0] size_q;
	logic [CW-1:0]              addr;
	logic [CW-1:0]              wr_addr;
	logic                       wr_en;
	logic [bres_pkg::SYM_W-1:0] wr_data;
	logic                       swap;

	// Status for the controller.
	always_comb begin
		status.is_nl    = (symbol == bres_pkg::NEWLINE_CODE);
		status.cnt_zero = (cnt_q == '0);
		status.cnt_last = (cnt_q == CW'(DEPTH - 1));
		status.n_one    = (cnt_q == CW'(1));
		status.hi_last  = ((hi_q + CW'(1)) == cnt_q);
		status.lo_last  = ((lo_q + CW'(2)) == cnt_q);
		status.k_last   = ((k_q + CW'(1)) == cnt_q);
	end

	// The held entry moves down when the probed entry is smaller.
	assign swap = (cur_q > rd_q);

	// Read address for the next cycle.
	always_comb begin
		addr = '0;
		if (cmd.lo_wr) begin
			addr = lo_q + CW'(1);
		end else if (cmd.lo_cap) begin
			addr = hi_q;
		end else if (cmd.cmp_step) begin
			addr = status.hi_last ? hi_q : hi_q + CW'(1);
		end else if (cmd.emit_step) begin
			addr = status.k_last ? k_q : k_q + CW'(1);
		end
	end

	// Write port: loading, exchange during a compare, and closing a pass.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = symbol;
		if (cmd.store_sym) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q;
		end else if (cmd.cmp_step && swap) begin
			wr_en   = 1'b1;
			wr_addr = hi_q;
			wr_data = cur_q;
		end else if (cmd.lo_wr) begin
			wr_en   = 1'b1;
			wr_addr = lo_q;
			wr_data = cur_q;
		end
	end

	// Entry store with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[AW-1:0]] <= wr_data;
		end
		rd_q <= mem[addr[AW-1:0]];
	end

	// Held entry of the current pass.
	always_ff @(posedge clk) begin
		if (cmd.lo_cap || (cmd.cmp_step && swap)) begin
			cur_q <= rd_q;
		end
	end

	// Fill count and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lo_q  <= '0;
			hi_q  <= '0;
			k_q   <= '0;
		end else begin
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (cmd.store_sym) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.sort_init) begin
				lo_q <= '0;
				hi_q <= CW'(1);
			end else if (cmd.lo_wr) begin
				lo_q <= lo_q + CW'(1);
				hi_q <= lo_q + CW'(2);
			end else if (cmd.cmp_step) begin
				hi_q <= hi_q + CW'(1);
			end
			if (cmd.emit_init) begin
				k_q <= '0;
			end else if (cmd.emit_step) begin
				k_q <= k_q + CW'(1);
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_q <= bres_pkg::FONT_RESET;
			size_q <= bres_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == bres_pkg::CFG_FONT) begin
				font_q <= cfg_data;
			end else if (cfg_index == bres_pkg::CFG_SIZE) begin
				size_q <= cfg_data;
			end
		end
	end

	assign sorted_symbol = rd_q;
	assign font          = font_q;
	assign size          = size_q;

endmodule

`default_nettype wire

// ===== rtl/byte_record_exchange_sorter_top.sv =====
// Top level of the byte record exchange sorter.
//
//   channel   handshake                  payload
//   input     start, busy                symbol
//   result    result_strobe              sorted_symbol, font, size, last
//   config    cfg_we                     cfg_index, cfg_data
//
// Each byte other than the newline is stored while start is high and the block is
// idle. The single read and write port of the entry store allows one compare per
// cycle during the sort. Records leave one per cycle at the end.
// Reset clears the fill count and the controller; the store needs no clearing.
// The receiver cannot stall: every record is taken in the cycle it is shown.
`timescale 1ns / 1ps
`default_nettype none

module byte_record_exchange_sorter_top #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [bres_pkg::SYM_W-1:0]     symbol,
	output logic                                result_strobe,
	output logic [bres_pkg::SYM_W-1:0]          sorted_symbol,
	output logic [bres_pkg::CFG_W-1:0]          font,
	output logic [bres_pkg::CFG_W-1:0]          size,
	output logic                                last,
	input  wire logic                           cfg_we,
	input  wire logic [bres_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bres_pkg::CFG_W-1:0]     cfg_data
);

	bres_pkg::cmd_t    cmd;
	bres_pkg::status_t status;

	// Sequencing of loading, sorting and emitting.
	bres_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Store, counters, compare and configuration registers.
	bres_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.symbol        (symbol),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sorted_symbol (sorted_symbol),
		.font          (font),
		.size          (size)
	);

	// A record is shown in each emit cycle; the final one carries last.
	assign result_strobe = cmd.emit_step;
	assign last          = cmd.emit_step & status.k_last;

endmodule

`default_nettype wire

// ===== tb/byte_record_exchange_sorter_checker.sv =====
// Checker for the byte record exchange sorter: predicts sorted records and compares them.
`timescale 1ns / 1ps

module byte_record_exchange_sorter_checker #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic                           busy,
	input  wire logic [bres_pkg::SYM_W-1:0]     symbol,
	input  wire logic                           result_strobe,
	input  wire logic [bres_pkg::SYM_W-1:0]     sorted_symbol,
	input  wire logic [bres_pkg::CFG_W-1:0]     font,
	input  wire logic [bres_pkg::CFG_W-1:0]     size,
	input  wire logic                           last,
	input  wire logic                           cfg_we,
	input  wire logic [bres_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bres_pkg::CFG_W-1:0]     cfg_data,
	output int                                  failures,
	output int                                  records_due
);

	typedef struct packed {
		logic [bres_pkg::SYM_W-1:0] sym;
		logic [bres_pkg::CFG_W-1:0] font;
		logic [bres_pkg::CFG_W-1:0] size;
		logic                       last;
	} sorted_record_t;

	// Predicted state: bytes held for the current set and the register copies.
	logic [bres_pkg::SYM_W-1:0] held_symbols[$];
	logic [bres_pkg::CFG_W-1:0] font_now;
	logic [bres_pkg::CFG_W-1:0] size_now;
	sorted_record_t             due_records[$];

	initial begin
		failures = 0;
		records_due = 0;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what);
		$display("%0t ns sorter check: %s", $time, what);
		failures++;
	endtask

	// Sorts the held bytes in ascending unsigned order and queues one record per byte.
	task automatic release_held_set();
		logic [bres_pkg::SYM_W-1:0] row[DEPTH];
		logic [bres_pkg::SYM_W-1:0] swap;
		sorted_record_t             rec;
		int                         n;
		n = held_symbols.size();
		for (int i = 0; i < n; i++)
			row[i] = held_symbols[i];
		for (int lo = 0; lo + 1 < n; lo++)
			for (int hi = lo + 1; hi < n; hi++)
				if (row[lo] > row[hi]) begin
					swap = row[lo];
					row[lo] = row[hi];
					row[hi] = swap;
				end
		for (int k = 0; k < n; k++) begin
			rec.sym = row[k];
			rec.font = font_now;
			rec.size = size_now;
			rec.last = (k == n - 1);
			due_records.push_back(rec);
		end
		held_symbols.delete();
	endtask

	// Everything is sampled at the rising edge, before the block's own updates land.
	always @(posedge clk or negedge arst_n) begin
		sorted_record_t want;
		if (!arst_n) begin
			held_symbols.delete();
			due_records.delete();
			font_now = bres_pkg::FONT_RESET;
			size_now = bres_pkg::SIZE_RESET;
		end else begin
			// Compare a record shown in this cycle with the oldest one due.
			if (result_strobe) begin
				if (due_records.size() == 0) begin
					report_mismatch($sformatf("record %02h arrived with none due", sorted_symbol));
				end else begin
					want = due_records.pop_front();
					if (sorted_symbol !== want.sym)
						report_mismatch($sformatf("sorted_symbol %02h, wanted %02h",
							sorted_symbol, want.sym));
					if (font !== want.font)
						report_mismatch($sformatf("font %04h, wanted %04h", font, want.font));
					if (size !== want.size)
						report_mismatch($sformatf("size %04h, wanted %04h", size, want.size));
					if (last !== want.last)
						report_mismatch($sformatf("last %b, wanted %b on symbol %02h",
							last, want.last, want.sym));
				end
			end

			// Register writes; indexes beyond the two registers change nothing.
			if (cfg_we) begin
				if (cfg_index == bres_pkg::CFG_FONT)
					font_now = cfg_data;
				else if (cfg_index == bres_pkg::CFG_SIZE)
					size_now = cfg_data;
			end

			// An accepted item either closes the set or is held, and a full store closes it too.
			if (start && !busy) begin
				if (symbol == bres_pkg::NEWLINE_CODE) begin
					release_held_set();
				end else begin
					held_symbols.push_back(symbol);
					if (held_symbols.size() >= DEPTH)
						release_held_set();
				end
			end
		end
		records_due = due_records.size();
	end

endmodule

// ===== tb/byte_record_exchange_sorter_top_tb.sv =====
// Testbench top for the byte record exchange sorter: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module byte_record_exchange_sorter_top_tb;

	localparam int unsigned DEPTH = 16;
	// Register indexes that address nothing.
	localparam logic [bres_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [bres_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 100;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DRAIN_CYCLES = 200;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic [bres_pkg::SYM_W-1:0]     symbol = '0;
	logic                           cfg_we = 1'b0;
	logic [bres_pkg::CFG_IDX_W-1:0] cfg_index = bres_pkg::CFG_FONT;
	logic [bres_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                           busy;
	logic                           result_strobe;
	logic [bres_pkg::SYM_W-1:0]     sorted_symbol;
	logic [bres_pkg::CFG_W-1:0]     font;
	logic [bres_pkg::CFG_W-1:0]     size;
	logic                           last;
	int                             failures;
	int                             records_due;
	int                             items_sent = 0;
	bit                             burst = 1'b0;

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	byte_record_exchange_sorter_top #(.DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.symbol(symbol),
		.result_strobe(result_strobe),
		.sorted_symbol(sorted_symbol),
		.font(font),
		.size(size),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	byte_record_exchange_sorter_checker #(.DEPTH(DEPTH)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.symbol(symbol),
		.result_strobe(result_strobe),
		.sorted_symbol(sorted_symbol),
		.font(font),
		.size(size),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.records_due(records_due)
	);

	// Gap after an item: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Register value with the extremes well represented.
	function automatic logic [bres_pkg::CFG_W-1:0] pick_reg_value();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return 16'($urandom_range(0, 65535));
	endfunction

	// Content byte of a set: anything but the newline, sometimes from a tiny alphabet.
	function automatic logic [bres_pkg::SYM_W-1:0] pick_content(input bit narrow);
		logic [bres_pkg::SYM_W-1:0] v;
		do begin
			v = narrow ? 8'($urandom_range(8'h41, 8'h44)) : 8'($urandom_range(0, 255));
		end while (v == bres_pkg::NEWLINE_CODE);
		return v;
	endfunction

	// Offers one item and holds it until the block takes it, then maybe idles.
	task automatic push_symbol(input logic [bres_pkg::SYM_W-1:0] sym);
		int gap;
		start <= 1'b1;
		symbol <= sym;
		do @(posedge clk); while (busy);
		items_sent++;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Closes a set with a newline.
	task automatic push_newline();
		push_symbol(bres_pkg::NEWLINE_CODE);
	endtask

	// Waits until no record is due and the block is idle, then lets it settle.
	task automatic wait_quiet();
		start <= 1'b0;
		do @(negedge clk); while (records_due != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bres_pkg::CFG_IDX_W-1:0] idx,
		input logic [bres_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Sets both registers while idle, with an optional write to an unused index.
	task automatic set_registers(input logic [bres_pkg::CFG_W-1:0] f,
		input logic [bres_pkg::CFG_W-1:0] s, input bit spare);
		wait_quiet();
		write_reg(bres_pkg::CFG_FONT, f);
		write_reg(bres_pkg::CFG_SIZE, s);
		if (spare)
			write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, pick_reg_value());
		cfg_we <= 1'b0;
	endtask

	// Random set: a length that reaches past a full store at times, random content.
	task automatic push_random_set();
		int  len;
		int  r;
		bit  narrow;
		r = $urandom_range(0, 99);
		narrow = ($urandom_range(0, 9) < 3);
		if (r < 10)
			len = 0;
		else if (r < 60)
			len = $urandom_range(1, 6);
		else if (r < 80)
			len = $urandom_range(7, 14);
		else if (r < 90)
			len = DEPTH - 1;
		else
			len = $urandom_range(DEPTH, DEPTH + 4);
		for (int i = 0; i < len; i++)
			push_symbol(pick_content(narrow));
		// A set of exactly a full store closes itself.
		if (len != DEPTH)
			push_newline();
	endtask

	// Noise: a few bytes of any value, newline included, with no closing newline.
	task automatic push_noise();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) push_symbol(8'($urandom_range(0, 255)));
	endtask

	initial begin
		int spins;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A newline with nothing held gives no records.
		push_newline();
		// Extremes and a repeated byte under the reset register values; signed order would differ.
		push_symbol(8'hFF);
		push_symbol(8'h00);
		push_symbol(8'h80);
		push_symbol(8'h7F);
		push_symbol(8'h80);
		push_newline();

		// Register extremes and an ignored write, then a full store that closes without a newline.
		set_registers('1, '0, 1'b1);
		for (int i = 0; i < DEPTH; i++)
			push_symbol(8'hF0 - 8'(i));

		// Registers change while a byte is held: the later values go out with it.
		push_symbol(8'h41);
		set_registers('0, '1, 1'b0);
		push_newline();

		// Random sets with occasional noise and register changes.
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				set_registers(pick_reg_value(), pick_reg_value(), 1'($urandom_range(0, 1)));
			burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				push_noise();
			else
				push_random_set();
		end
		burst = 1'b0;
		// Close whatever noise left behind.
		push_newline();
		start <= 1'b0;

		// Drain, with a bound.
		spins = 0;
		do begin
			@(negedge clk);
			spins++;
		end while ((records_due != 0 || busy) && spins < 5000);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && records_due == 0)
			$display("byte_record_exchange_sorter_top_tb: clean");
		else
			$display("byte_record_exchange_sorter_top_tb: errors");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#2000000;
		$display("byte_record_exchange_sorter_top_tb: errors");
		$finish;
	end

endmodule
